// ----- rtl/pra_pkg.sv -----
package pra_pkg;

   localparam int HeapPages = 1024;
   localparam int PageW     = 10;
   localparam int SizeW     = 11;

   typedef logic [PageW-1:0] page_type;
   typedef logic [SizeW-1:0] size_type;

   localparam logic [1:0] StatusOk      = 2'd0;
   localparam logic [1:0] StatusNoSpace = 2'd1;
   localparam logic [1:0] StatusBadFree = 2'd2;

   localparam logic ModeAlloc = 1'b0;
   localparam logic ModeFree  = 1'b1;

   typedef enum logic [8:0] {
      ST_CLEAR = 9'b000000001,
      ST_IDLE  = 9'b000000010,
      ST_SCAN  = 9'b000000100,
      ST_SWAIT = 9'b000001000,
      ST_MARK  = 9'b000010000,
      ST_FSIZE = 9'b000100000,
      ST_FWALK = 9'b001000000,
      ST_LOWER = 9'b010000000,
      ST_LWAIT = 9'b100000000
   } state_type;

endpackage

// ----- rtl/page_run_allocator_exact_worst_fit.sv -----
// Channel | Dir | Beat contents (lowest bit first)
// csr     | in  | csr_data: region_start_page[9:0]
// req     | in  | req_tuser: mode[0]; req_tdata: page_count[10:0], free_page[20:11], fill to 24
// rsp     | out | rsp_tdata: status[1:0], start_page[11:2], zero fill to 16
// After reset a clearing pass sweeps both 1024-entry tables; no request is taken meanwhile.
// An allocation reads the bitmap from the region start to the break, stopping early after an
// exact-fit run, then marks the granted run one page per cycle.
// A free reads the size entry, clears the run one page per cycle, then walks the break down
// past free pages. One request is in flight at a time; the result register holds a
// stalled beat while the bitmap port stays idle.
module page_run_allocator_exact_worst_fit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [9:0]  csr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // page_count, free_page
   input  logic        req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // status, start_page
);

   logic              used_mem [pra_pkg::HeapPages];
   pra_pkg::size_type size_mem [pra_pkg::HeapPages];

   pra_pkg::state_type state_ff, state_in;
   logic [pra_pkg::SizeW-1:0] p_ff, p_in;
   logic [pra_pkg::SizeW-1:0] brk_ff, brk_in;
   pra_pkg::page_type         rs_ff, rs_in;
   pra_pkg::size_type         n_ff, n_in;
   logic [pra_pkg::SizeW-1:0] run_start_ff, run_start_in, run_len_ff, run_len_in;
   logic [pra_pkg::SizeW-1:0] big_start_ff, big_start_in, big_len_ff, big_len_in;
   logic [pra_pkg::SizeW-1:0] grant_ff, grant_in, end_ff, end_in;
   logic                      rv_ff, rv_in;
   logic [1:0]                rst_ff, rst_in;
   pra_pkg::page_type         rpg_ff, rpg_in;

   logic                      rd_used_q;
   pra_pkg::size_type         rd_size_q;
   logic                      u_we, u_wd, s_we;
   pra_pkg::page_type         u_addr, s_addr;
   pra_pkg::size_type         s_wd;

   logic req_acc, room;
   logic [pra_pkg::SizeW-1:0] base, cnt;
   logic [pra_pkg::SizeW:0]   lim;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {4'd0, rpg_ff, rst_ff};
   assign room       = !rv_ff || rsp_tready;
   assign req_tready = (state_ff == pra_pkg::ST_IDLE) && room;
   assign req_acc    = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (u_we) used_mem[u_addr] <= u_wd;
      rd_used_q <= used_mem[u_addr];
      if (s_we) size_mem[s_addr] <= s_wd;
      rd_size_q <= size_mem[s_addr];
   end

   always_comb begin
      state_in = state_ff; p_in = p_ff; brk_in = brk_ff; rs_in = rs_ff; n_in = n_ff;
      run_start_in = run_start_ff; run_len_in = run_len_ff;
      big_start_in = big_start_ff; big_len_in = big_len_ff;
      grant_in = grant_ff; end_in = end_ff;
      rv_in = rv_ff && !rsp_tready; rst_in = rst_ff; rpg_in = rpg_ff;
      u_we = 1'b0; u_wd = 1'b0; u_addr = p_ff[pra_pkg::PageW-1:0];
      s_we = 1'b0; s_wd = '0; s_addr = p_ff[pra_pkg::PageW-1:0];
      base = (brk_ff < {1'b0, rs_ff}) ? {1'b0, rs_ff} : brk_ff;
      cnt = req_tdata[10:0];
      lim = (pra_pkg::SizeW+1)'(pra_pkg::HeapPages);
      if (csr_valid && csr_ready) rs_in = csr_data;
      case (state_ff)
         pra_pkg::ST_CLEAR: begin
            u_we = 1'b1; s_we = 1'b1;
            p_in = p_ff + 1'b1;
            if (p_ff == pra_pkg::SizeW'(pra_pkg::HeapPages - 1)) begin
               state_in = pra_pkg::ST_IDLE;
            end
         end
         pra_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (req_tuser == pra_pkg::ModeAlloc) begin
                  n_in = cnt;
                  if (cnt == '0 || {1'b0, cnt} > lim - {2'b0, rs_ff}) begin
                     rv_in = 1'b1; rst_in = pra_pkg::StatusNoSpace; rpg_in = '0;
                  end else begin
                     p_in = {1'b0, rs_ff};
                     run_len_in = '0; run_start_in = '0; big_len_in = '0; big_start_in = '0;
                     state_in = pra_pkg::ST_SCAN;
                  end
               end else begin
                  if (req_tdata[20:11] < rs_ff) begin
                     rv_in = 1'b1; rst_in = pra_pkg::StatusBadFree; rpg_in = '0;
                  end else begin
                     p_in = {1'b0, req_tdata[20:11]};
                     s_addr = req_tdata[20:11];
                     state_in = pra_pkg::ST_FSIZE;
                  end
               end
            end
         end
         pra_pkg::ST_SCAN: begin
            if (p_ff < brk_ff) begin
               state_in = pra_pkg::ST_SWAIT;
            end else begin
               if (run_len_ff == n_ff) begin
                  grant_in = run_start_ff; state_in = pra_pkg::ST_MARK;
                  p_in = run_start_ff; end_in = run_start_ff + n_ff;
               end else if (run_len_ff > big_len_ff ? run_len_ff >= n_ff
                                                    : big_len_ff >= n_ff) begin
                  grant_in = run_len_ff > big_len_ff ? run_start_ff : big_start_ff;
                  p_in = grant_in; end_in = grant_in + n_ff; state_in = pra_pkg::ST_MARK;
               end else if ({1'b0, n_ff} > lim - {1'b0, base}) begin
                  rv_in = 1'b1; rst_in = pra_pkg::StatusNoSpace; rpg_in = '0;
                  state_in = pra_pkg::ST_IDLE;
               end else begin
                  grant_in = base; p_in = base; end_in = base + n_ff;
                  brk_in = base + n_ff; state_in = pra_pkg::ST_MARK;
               end
            end
         end
         pra_pkg::ST_SWAIT: begin
            p_in = p_ff + 1'b1;
            state_in = pra_pkg::ST_SCAN;
            if (!rd_used_q) begin
               if (run_len_ff == '0) run_start_in = p_ff;
               run_len_in = run_len_ff + 1'b1;
            end else if (run_len_ff == n_ff) begin
               grant_in = run_start_ff; p_in = run_start_ff;
               end_in = run_start_ff + n_ff; state_in = pra_pkg::ST_MARK;
            end else begin
               if (run_len_ff > big_len_ff) begin
                  big_len_in = run_len_ff; big_start_in = run_start_ff;
               end
               run_len_in = '0; run_start_in = '0;
            end
         end
         pra_pkg::ST_MARK: begin
            if (p_ff < end_ff) begin
               u_we = 1'b1; u_wd = 1'b1; p_in = p_ff + 1'b1;
            end else begin
               s_we = 1'b1; s_addr = grant_ff[pra_pkg::PageW-1:0]; s_wd = n_ff;
               rv_in = 1'b1; rst_in = pra_pkg::StatusOk;
               rpg_in = grant_ff[pra_pkg::PageW-1:0];
               state_in = pra_pkg::ST_IDLE;
            end
         end
         pra_pkg::ST_FSIZE: begin
            s_we = 1'b1;
            end_in = p_ff + rd_size_q;
            if ((pra_pkg::SizeW+1)'(p_ff) + (pra_pkg::SizeW+1)'(rd_size_q) > lim)
               end_in = pra_pkg::SizeW'(pra_pkg::HeapPages);
            state_in = pra_pkg::ST_FWALK;
         end
         pra_pkg::ST_FWALK: begin
            if (p_ff < end_ff) begin
               u_we = 1'b1; p_in = p_ff + 1'b1;
            end else begin
               state_in = pra_pkg::ST_LOWER;
            end
         end
         pra_pkg::ST_LOWER: begin
            u_addr = pra_pkg::PageW'(brk_ff - 1'b1);
            if (brk_ff > {1'b0, rs_ff}) begin
               state_in = pra_pkg::ST_LWAIT;
            end else begin
               rv_in = 1'b1; rst_in = pra_pkg::StatusOk; rpg_in = '0;
               state_in = pra_pkg::ST_IDLE;
            end
         end
         pra_pkg::ST_LWAIT: begin
            if (!rd_used_q) begin
               brk_in = brk_ff - 1'b1; state_in = pra_pkg::ST_LOWER;
            end else begin
               rv_in = 1'b1; rst_in = pra_pkg::StatusOk; rpg_in = '0;
               state_in = pra_pkg::ST_IDLE;
            end
         end
         default: state_in = pra_pkg::ST_IDLE;
      endcase
      if (state_ff != pra_pkg::ST_IDLE && state_ff != pra_pkg::ST_CLEAR &&
          state_in == pra_pkg::ST_IDLE && !room) begin
         state_in = state_ff; rv_in = rv_ff;
         u_we = 1'b0; s_we = 1'b0; brk_in = brk_ff;
         p_in = p_ff; grant_in = grant_ff; end_in = end_ff;
         big_len_in = big_len_ff; big_start_in = big_start_ff;
         run_len_in = run_len_ff; run_start_in = run_start_ff;
         rst_in = rst_ff; rpg_in = rpg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pra_pkg::ST_CLEAR;
         p_ff     <= '0;
         brk_ff   <= '0;
         rs_ff    <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         p_ff     <= p_in;
         brk_ff   <= brk_in;
         rs_ff    <= rs_in;
         rv_ff    <= rv_in;
      end
      n_ff <= n_in;
      run_start_ff <= run_start_in; run_len_ff <= run_len_in;
      big_start_ff <= big_start_in; big_len_ff <= big_len_in;
      grant_ff <= grant_in; end_ff <= end_in;
      rst_ff <= rst_in; rpg_ff <= rpg_in;
   end

   a_one_hot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_brk_range: assert property (@(posedge clock) disable iff (reset)
      brk_ff <= pra_pkg::SizeW'(pra_pkg::HeapPages))
      else $error("break beyond heap");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != pra_pkg::ST_IDLE |-> !req_tready)
      else $error("request taken while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rsp_tready |=> rv_ff && $stable(rsp_tdata))
      else $error("result lost under stall");

endmodule

// ----- dv/tb.sv -----
module tb;

   typedef struct packed {
      logic              mode;
      pra_pkg::size_type count;
      pra_pkg::page_type page;
   } req_beat_type;

   typedef struct packed {
      logic [1:0]        status;
      pra_pkg::page_type start;
   } grant_type;

   localparam int unsigned CycleLimit = 8000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [9:0]  csr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   page_run_allocator_exact_worst_fit i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),         // region_start_page
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),        // page_count, free_page
      .req_tuser  (req_tuser),        // mode
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)         // status, start_page
   );

   always #5 clock = ~clock;

   logic            used_map [pra_pkg::HeapPages];
   int unsigned     run_len_at [pra_pkg::HeapPages];
   int unsigned     brk;
   int unsigned     region;

   req_beat_type    pending_reqs [$];
   grant_type       grants_due [$];
   int unsigned     live_starts [$];
   int unsigned     errors = 0;
   int unsigned     cycles = 0;
   bit              quiet = 1'b0;
   int unsigned     req_gap = 0;
   int unsigned     rsp_gap = 0;

   function automatic grant_type alloc_pages(int unsigned n);
      grant_type   g;
      int unsigned run_start, run_len, big_start, big_len, exact_start, grant, base;
      bit          exact;
      g = '{status: pra_pkg::StatusNoSpace, start: '0};
      run_start = 0; run_len = 0; big_start = 0; big_len = 0; exact_start = 0; exact = 0;
      if (n == 0 || region >= pra_pkg::HeapPages || n > pra_pkg::HeapPages - region) return g;
      for (int unsigned p = region; p < brk && p < pra_pkg::HeapPages; p++) begin
         if (!used_map[p]) begin
            if (run_len == 0) run_start = p;
            run_len++;
         end else begin
            if (run_len == n) begin
               exact = 1;
               exact_start = run_start;
               break;
            end
            if (run_len > big_len) begin
               big_len = run_len;
               big_start = run_start;
            end
            run_len = 0;
            run_start = 0;
         end
      end
      if (!exact && run_len == n) begin
         exact = 1;
         exact_start = run_start;
      end
      if (run_len > big_len) begin
         big_len = run_len;
         big_start = run_start;
      end
      if (exact) begin
         grant = exact_start;
      end else if (big_len >= n) begin
         grant = big_start;
      end else begin
         base = (brk < region) ? region : brk;
         if (base > pra_pkg::HeapPages || n > pra_pkg::HeapPages - base) return g;
         grant = base;
         brk = base + n;
      end
      for (int unsigned p = grant; p < grant + n && p < pra_pkg::HeapPages; p++)
         used_map[p] = 1'b1;
      run_len_at[grant] = n;
      g.status = pra_pkg::StatusOk;
      g.start = pra_pkg::page_type'(grant);
      return g;
   endfunction

   function automatic grant_type release_pages(int unsigned pg);
      int unsigned len;
      if (pg < region || pg >= pra_pkg::HeapPages)
         return '{status: pra_pkg::StatusBadFree, start: '0};
      len = run_len_at[pg];
      run_len_at[pg] = 0;
      for (int unsigned p = pg; p < pg + len && p < pra_pkg::HeapPages; p++)
         used_map[p] = 1'b0;
      while (brk > region && brk <= pra_pkg::HeapPages && !used_map[brk-1]) brk--;
      return '{status: pra_pkg::StatusOk, start: '0};
   endfunction

   // driver
   always @(posedge clock) begin
      req_beat_type b;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            b = '{mode: req_tuser, count: req_tdata[10:0], page: req_tdata[20:11]};
            grants_due.push_back(b.mode == pra_pkg::ModeFree ? release_pages(b.page)
                                                             : alloc_pages(b.count));
         end
         if (req_tvalid && !req_tready) begin
            // hold
         end else if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            req_gap = $urandom_range(0, 14);
            req_tvalid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            b = pending_reqs.pop_front();
            req_tdata <= {3'b000, b.page, b.count};
            req_tuser <= b.mode;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      grant_type g;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (grants_due.size() == 0) begin
               $display("%0t: unexpected beat %h", $realtime, rsp_tdata);
               errors++;
            end else begin
               g = grants_due.pop_front();
               if (rsp_tdata[1:0] !== g.status) begin
                  $display("%0t: status expected %0d actual %0d", $realtime, g.status,
                           rsp_tdata[1:0]);
                  errors++;
               end
               if (rsp_tdata[11:2] !== g.start) begin
                  $display("%0t: start_page expected %0d actual %0d", $realtime, g.start,
                           rsp_tdata[11:2]);
                  errors++;
               end
               if (rsp_tdata[15:12] !== 4'b0) begin
                  $display("%0t: fill expected 0 actual %h", $realtime, rsp_tdata[15:12]);
                  errors++;
               end
               if (g.status == pra_pkg::StatusOk && g.start != 0 ||
                   g.status == pra_pkg::StatusOk && $urandom_range(0, 1) == 0)
                  live_starts.push_back(g.start);
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_gap = $urandom_range(0, 14);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("** page_run_allocator_exact_worst_fit: FAILED **");
         $finish;
      end
   end

   task automatic push_req(logic mode, int unsigned count, int unsigned pg);
      while (pending_reqs.size() >= 2) @(posedge clock);
      pending_reqs.push_back('{mode: mode, count: pra_pkg::size_type'(count),
                               page: pra_pkg::page_type'(pg)});
   endtask

   task automatic drain();
      do @(negedge clock);
      while (pending_reqs.size() > 0 || req_tvalid || grants_due.size() > 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_region(int unsigned v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v[9:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      region = v;
      live_starts.delete();
   endtask

   task automatic random_req();
      int unsigned r, k;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         push_req(pra_pkg::ModeAlloc, $urandom_range(1, 12), $urandom_range(0, 1023));
      end else if (r < 50) begin
         push_req(pra_pkg::ModeAlloc, $urandom_range(0, 2047), $urandom_range(0, 1023));
      end else if (r < 85 && live_starts.size() > 0) begin
         k = $urandom_range(0, live_starts.size() - 1);
         push_req(pra_pkg::ModeFree, $urandom_range(0, 2047), live_starts[k]);
         live_starts.delete(k);
      end else if (r < 95) begin
         push_req(pra_pkg::ModeFree, $urandom_range(0, 2047), $urandom_range(0, 1023));
      end else begin
         push_req(pra_pkg::ModeAlloc, $urandom_range(1, 4), $urandom_range(0, 1023));
      end
   endtask

   initial begin
      int unsigned regions [6] = '{0, 1023, 5, 300, 1000, 0};
      for (int i = 0; i < pra_pkg::HeapPages; i++) begin
         used_map[i] = 1'b0;
         run_len_at[i] = 0;
      end
      brk = 0;
      region = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_region(0);
      push_req(pra_pkg::ModeAlloc, 0, 0);
      push_req(pra_pkg::ModeAlloc, 1025, 0);
      push_req(pra_pkg::ModeAlloc, 2047, 1023);
      push_req(pra_pkg::ModeAlloc, 1024, 0);
      push_req(pra_pkg::ModeAlloc, 1, 0);
      push_req(pra_pkg::ModeFree, 0, 0);
      push_req(pra_pkg::ModeAlloc, 3, 0);
      push_req(pra_pkg::ModeAlloc, 2, 0);
      push_req(pra_pkg::ModeAlloc, 3, 0);
      push_req(pra_pkg::ModeAlloc, 1, 0);
      push_req(pra_pkg::ModeFree, 0, 0);
      push_req(pra_pkg::ModeAlloc, 3, 0);
      push_req(pra_pkg::ModeFree, 3, 0);
      push_req(pra_pkg::ModeAlloc, 1, 0);
      push_req(pra_pkg::ModeFree, 7, 0);
      push_req(pra_pkg::ModeFree, 8, 0);
      push_req(pra_pkg::ModeAlloc, 1, 0);
      push_req(pra_pkg::ModeFree, 2047, 1023);
      push_req(pra_pkg::ModeFree, 0, 513);
      drain();
      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) begin
            write_region(regions[ph]);
            push_req(pra_pkg::ModeFree, 0, 0);
            push_req(pra_pkg::ModeFree, 0, 1023);
            push_req(pra_pkg::ModeAlloc, 1, 0);
            push_req(pra_pkg::ModeAlloc, 1024 - regions[ph], 0);
            push_req(pra_pkg::ModeAlloc, 1025 - regions[ph], 0);
         end
         quiet = (ph == 5);
         for (int i = 0; i < 90; i++) random_req();
         drain();
      end
      if (errors == 0) begin
         $display("** page_run_allocator_exact_worst_fit: PASSED **");
      end else begin
         $display("** page_run_allocator_exact_worst_fit: FAILED **");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/pra_pkg.sv
rtl/page_run_allocator_exact_worst_fit.sv
dv/tb.sv
